>>> rtl/bki_pkg.sv
// ----------------------------------------------------------------------------
// bki_pkg: shared widths, constants and types of the keyframe interpolator
// Widths of the segment data, the numerator datapath and the divider.
// ----------------------------------------------------------------------------
package bki_pkg;

  // Frame count and segment sizing
  localparam int CNT_W      = 7;
  localparam int MAX_SKIP   = 64;

  // Keyframe values and six-times control points
  localparam int CP_W       = 32;
  localparam int A6_W       = 36;

  // Squares, Bernstein coefficients, numerator and divider
  localparam int SQ_W        = 13;
  localparam int COEF_W      = 21;
  localparam int D_W         = 21;
  localparam int NUM_W       = 58;
  localparam int POLY_STAGES = 6;
  localparam int Q_W         = 32;
  localparam int MAG_W       = Q_W + D_W;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = Q_W / DIV_STEPS;

  // Cycles the divisor needs to settle after a skip count write
  localparam int CFG_WAIT_W = 2;
  localparam logic [CFG_WAIT_W-1:0] CFG_SETTLE = 2'd2;

  // Saturation limits of a result value
  localparam logic [CP_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [CP_W-1:0] VAL_MIN = 32'h8000_0000;

  // Frame index and end-of-segment mark traveling with each evaluation
  typedef struct packed {
    logic [CNT_W-1:0] k;
    logic             last;
  } tag_t;

  // Segment end points and six-times inner control points
  typedef struct packed {
    logic signed [CP_W-1:0] p1;
    logic signed [CP_W-1:0] p2;
    logic signed [A6_W-1:0] a6;
    logic signed [A6_W-1:0] b6;
  } cp_t;

endpackage

>>> rtl/bezier_keyframe_interpolator_top.sv
// ----------------------------------------------------------------------------
// bezier_keyframe_interpolator_top: cubic Bezier keyframe in-betweening
// Turns one keyframe segment into skip_count interpolated values.
// ----------------------------------------------------------------------------
// Usage:
//   Segment channel (seg_valid / seg_stall): previous, start, end and next
//   keyframe values in signed Q16.16 with neighbor flags. One transaction is
//   one segment.
//   Result channel (res_valid / res_stall): value, frame_offset and last, one
//   transaction per in-between frame, last set on the final frame.
//   Config channel (cfg_valid / cfg_ready, skip_count): write only while idle;
//   counts above 64 act as 64, a count of zero drops the segment.
// Throughput: a segment holds the input until its last frame issues; one with
//   a zero count issues none. The evaluator issues one frame per cycle, so
//   results stream at one per cycle while the receiver keeps up.
// Pipeline: an accepted segment is captured in a register; each frame then
//   passes one issue stage, six numerator stages, eight divider stages of
//   four quotient bits each, and the output register.
// Reset: skip_count returns to 1; seg_stall stays high after reset and after
//   every configuration write while the divisor settles.
// Stall: res_stall holds the output register while valid; stages behind it
//   keep filling bubbles and then hold, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bezier_keyframe_interpolator_top import bki_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       skip_count,
  input  logic                   seg_valid,
  output logic                   seg_stall,
  input  logic signed [CP_W-1:0] prev_value,
  input  logic signed [CP_W-1:0] start_value,
  input  logic signed [CP_W-1:0] end_value,
  input  logic signed [CP_W-1:0] next_value,
  input  logic                   has_prev,
  input  logic                   has_next,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic signed [CP_W-1:0] value,
  output logic [CNT_W-1:0]       frame_offset,
  output logic                   last
);

  logic             iss_valid;
  logic [CNT_W-1:0] iss_m;
  tag_t             iss_tag;
  cp_t              iss_cp;
  logic [D_W-1:0]   div_d;
  logic             poly_take;
  logic             poly_valid;
  tag_t             poly_tag;
  logic             poly_neg;
  logic [MAG_W-1:0] poly_mag;
  logic             div_take;
  logic             div_valid;
  tag_t             div_tag;
  logic             div_neg;
  logic [Q_W-1:0]   div_quo;
  logic             out_take;
  logic [CP_W-1:0]  sat;

  bki_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .skip_count  (skip_count),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .prev_value  (prev_value),
    .start_value (start_value),
    .end_value   (end_value),
    .next_value  (next_value),
    .has_prev    (has_prev),
    .has_next    (has_next),
    .dn_take     (poly_take),
    .iss_valid   (iss_valid),
    .iss_m       (iss_m),
    .iss_tag     (iss_tag),
    .iss_cp      (iss_cp),
    .div_d       (div_d)
  );

  bki_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iss_valid),
    .in_m      (iss_m),
    .in_tag    (iss_tag),
    .in_cp     (iss_cp),
    .up_take   (poly_take),
    .dn_take   (div_take),
    .out_valid (poly_valid),
    .out_tag   (poly_tag),
    .out_neg   (poly_neg),
    .out_mag   (poly_mag)
  );

  bki_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (poly_valid),
    .in_tag    (poly_tag),
    .in_neg    (poly_neg),
    .in_mag    (poly_mag),
    .div_d     (div_d),
    .up_take   (div_take),
    .dn_take   (out_take),
    .out_valid (div_valid),
    .out_tag   (div_tag),
    .out_neg   (div_neg),
    .out_quo   (div_quo)
  );

  // Load the output register when it is empty or its transaction is taken
  assign out_take = !res_valid || !res_stall;

  // Restore the sign and saturate to 32 bits
  always_comb begin
    if (div_neg) begin
      sat = (div_quo > VAL_MIN) ? VAL_MIN : -div_quo;
    end else begin
      sat = div_quo[Q_W-1] ? VAL_MAX : div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_take) begin
      res_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      value        <= $signed(sat);
      frame_offset <= div_tag.k;
      last         <= div_tag.last;
    end
  end

endmodule

>>> rtl/bki_seq.sv
// ----------------------------------------------------------------------------
// bki_seq: segment capture and frame sequencer
// Derives the inner control points of an accepted segment, holds the skip count
// and the divisor 6*(n^3), and issues one frame index per cycle while downstream takes them.
// ----------------------------------------------------------------------------
module bki_seq import bki_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       skip_count,
  input  logic                   seg_valid,
  output logic                   seg_stall,
  input  logic signed [CP_W-1:0] prev_value,
  input  logic signed [CP_W-1:0] start_value,
  input  logic signed [CP_W-1:0] end_value,
  input  logic signed [CP_W-1:0] next_value,
  input  logic                   has_prev,
  input  logic                   has_next,
  input  logic                   dn_take,
  output logic                   iss_valid,
  output logic [CNT_W-1:0]       iss_m,
  output tag_t                   iss_tag,
  output cp_t                    iss_cp,
  output logic [D_W-1:0]         div_d
);

  logic [CNT_W-1:0]      skip;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      n;
  logic [SQ_W-1:0]       n2;
  logic [CFG_WAIT_W-1:0] cfg_wait;
  logic                  act;
  logic [CNT_W-1:0]      kc;
  cp_t                   seg;
  cp_t                   seg_next;
  logic signed [A6_W-1:0] x0, x1, x2, x3;
  logic                  accept;
  logic                  take0;
  logic                  issue;
  logic                  at_last;

  assign cfg_ready = 1'b1;

  // Clamp the skip count and form n = count + 1
  assign cnt = (skip > CNT_W'(MAX_SKIP)) ? CNT_W'(MAX_SKIP) : skip;
  assign n   = cnt + CNT_W'(1);

  // Handshake of the segment channel and the issue stage
  assign take0     = !iss_valid || dn_take;
  assign issue     = act && take0;
  assign at_last   = (kc == cnt);
  assign seg_stall = (cfg_wait != '0) || (act && !(take0 && at_last));
  assign accept    = seg_valid && !seg_stall;

  // Derive six times the inner control points from the neighbors
  assign x0 = A6_W'(prev_value);
  assign x1 = A6_W'(start_value);
  assign x2 = A6_W'(end_value);
  assign x3 = A6_W'(next_value);

  always_comb begin
    seg_next.p1 = start_value;
    seg_next.p2 = end_value;
    if (has_prev) begin
      seg_next.a6 = (x1 <<< 2) + (x1 <<< 1) + x2 - x0;
    end else if (has_next) begin
      seg_next.a6 = (x1 <<< 2) + (x2 <<< 2) - (x3 <<< 1);
    end else begin
      seg_next.a6 = (x1 <<< 2) + (x2 <<< 1);
    end
    if (has_next) begin
      seg_next.b6 = (x2 <<< 2) + (x2 <<< 1) - x3 + x1;
    end else if (has_prev) begin
      seg_next.b6 = (x2 <<< 2) + (x1 <<< 2) - (x0 <<< 1);
    end else begin
      seg_next.b6 = (x1 <<< 1) + (x2 <<< 2);
    end
  end

  // Hold the skip count and wait for the divisor to settle
  always_ff @(posedge clk) begin
    if (rst) begin
      skip     <= CNT_W'(1);
      cfg_wait <= CFG_SETTLE;
    end else if (cfg_valid && cfg_ready) begin
      skip     <= skip_count;
      cfg_wait <= CFG_SETTLE;
    end else if (cfg_wait != '0) begin
      cfg_wait <= cfg_wait - CFG_WAIT_W'(1);
    end
  end

  // Build the divisor 6*n^3 through the n2 and div_d registers
  always_ff @(posedge clk) begin
    n2    <= SQ_W'(n) * SQ_W'(n);
    div_d <= (D_W'(n2) * D_W'(n)) * D_W'(6);
  end

  // Advance the frame counter; a new segment takes over at the current one's last frame
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      kc  <= CNT_W'(1);
    end else begin
      if (issue) begin
        if (at_last) begin
          act <= 1'b0;
        end else begin
          kc <= kc + CNT_W'(1);
        end
      end
      if (accept) begin
        act <= (cnt != '0);
        kc  <= CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg <= seg_next;
    end
  end

  // Issue stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
    end else if (take0) begin
      iss_valid <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (take0) begin
      iss_m        <= n - kc;
      iss_tag.k    <= kc;
      iss_tag.last <= at_last;
      iss_cp       <= seg;
    end
  end

endmodule

>>> rtl/bki_poly.sv
// ----------------------------------------------------------------------------
// bki_poly: Bernstein numerator pipeline
// Six stages: squares, coefficients, products, pair sums, total, magnitude.
// ----------------------------------------------------------------------------
module bki_poly import bki_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CNT_W-1:0] in_m,
  input  tag_t             in_tag,
  input  cp_t              in_cp,
  output logic             up_take,
  input  logic             dn_take,
  output logic             out_valid,
  output tag_t             out_tag,
  output logic             out_neg,
  output logic [MAG_W-1:0] out_mag
);

  logic [POLY_STAGES-1:0] v;
  logic [POLY_STAGES-1:0] take;

  // Stage 1
  logic [CNT_W-1:0] s1_m;
  logic [SQ_W-1:0]  s1_m2, s1_k2;
  tag_t             s1_tag;
  cp_t              s1_cp;
  // Stage 2
  logic [COEF_W-1:0] c0, c1, c2, c3;
  tag_t              s2_tag;
  cp_t               s2_cp;
  // Stage 3
  logic signed [NUM_W-1:0] t0, t1, t2, t3;
  tag_t                    s3_tag;
  // Stage 4
  logic signed [NUM_W-1:0] u01, u23;
  tag_t                    s4_tag;
  // Stage 5
  logic signed [NUM_W-1:0] num;
  tag_t                    s5_tag;
  // Stage 6 input
  logic signed [NUM_W-1:0] absn;

  // Let a stage load when it is empty or its content moves on
  always_comb begin
    take[POLY_STAGES-1] = !v[POLY_STAGES-1] || dn_take;
    for (int i = POLY_STAGES - 2; i >= 0; i--) begin
      take[i] = !v[i] || take[i+1];
    end
  end

  assign up_take   = take[0];
  assign out_valid = v[POLY_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (take[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < POLY_STAGES; i++) begin
        if (take[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Square the frame index and its complement
  always_ff @(posedge clk) begin
    if (take[0]) begin
      s1_m   <= in_m;
      s1_m2  <= SQ_W'(in_m) * SQ_W'(in_m);
      s1_k2  <= SQ_W'(in_tag.k) * SQ_W'(in_tag.k);
      s1_tag <= in_tag;
      s1_cp  <= in_cp;
    end
  end

  // Form 6m^3, 3m^2k, 3mk^2 and 6k^3
  always_ff @(posedge clk) begin
    if (take[1]) begin
      c0     <= (COEF_W'(s1_m2) * COEF_W'(s1_m)) * COEF_W'(6);
      c1     <= (COEF_W'(s1_m2) * COEF_W'(s1_tag.k)) * COEF_W'(3);
      c2     <= (COEF_W'(s1_k2) * COEF_W'(s1_m)) * COEF_W'(3);
      c3     <= (COEF_W'(s1_k2) * COEF_W'(s1_tag.k)) * COEF_W'(6);
      s2_tag <= s1_tag;
      s2_cp  <= s1_cp;
    end
  end

  // Weight each control point
  always_ff @(posedge clk) begin
    if (take[2]) begin
      t0     <= NUM_W'($signed({1'b0, c0})) * NUM_W'(s2_cp.p1);
      t1     <= NUM_W'($signed({1'b0, c1})) * NUM_W'(s2_cp.a6);
      t2     <= NUM_W'($signed({1'b0, c2})) * NUM_W'(s2_cp.b6);
      t3     <= NUM_W'($signed({1'b0, c3})) * NUM_W'(s2_cp.p2);
      s3_tag <= s2_tag;
    end
  end

  // Add in pairs
  always_ff @(posedge clk) begin
    if (take[3]) begin
      u01    <= t0 + t1;
      u23    <= t2 + t3;
      s4_tag <= s3_tag;
    end
  end

  // Total numerator
  always_ff @(posedge clk) begin
    if (take[4]) begin
      num    <= u01 + u23;
      s5_tag <= s4_tag;
    end
  end

  // Split into sign and magnitude for the divider
  assign absn = num[NUM_W-1] ? -num : num;

  always_ff @(posedge clk) begin
    if (take[5]) begin
      out_neg <= num[NUM_W-1];
      out_mag <= absn[MAG_W-1:0];
      out_tag <= s5_tag;
    end
  end

endmodule

>>> rtl/bki_div.sv
// ----------------------------------------------------------------------------
// bki_div: pipelined restoring divider
// Divides the numerator magnitude by 6*n^3, four quotient bits per stage.
// ----------------------------------------------------------------------------
module bki_div import bki_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tag_t             in_tag,
  input  logic             in_neg,
  input  logic [MAG_W-1:0] in_mag,
  input  logic [D_W-1:0]   div_d,
  output logic             up_take,
  input  logic             dn_take,
  output logic             out_valid,
  output tag_t             out_tag,
  output logic             out_neg,
  output logic [Q_W-1:0]   out_quo
);

  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES-1:0] take;
  logic [D_W-1:0]        rem      [DIV_STAGES];
  logic [Q_W-1:0]        qd       [DIV_STAGES];
  tag_t                  tg       [DIV_STAGES];
  logic                  ng       [DIV_STAGES];
  logic [D_W-1:0]        rem_src  [DIV_STAGES];
  logic [Q_W-1:0]        qd_src   [DIV_STAGES];
  tag_t                  tg_src   [DIV_STAGES];
  logic                  ng_src   [DIV_STAGES];
  logic                  v_src    [DIV_STAGES];
  logic [D_W-1:0]        rem_next [DIV_STAGES];
  logic [Q_W-1:0]        qd_next  [DIV_STAGES];

  // Let a stage load when it is empty or its content moves on
  always_comb begin
    take[DIV_STAGES-1] = !v[DIV_STAGES-1] || dn_take;
    for (int i = DIV_STAGES - 2; i >= 0; i--) begin
      take[i] = !v[i] || take[i+1];
    end
  end

  assign up_take   = take[0];
  assign out_valid = v[DIV_STAGES-1];
  assign out_tag   = tg[DIV_STAGES-1];
  assign out_neg   = ng[DIV_STAGES-1];
  assign out_quo   = qd[DIV_STAGES-1];

  // Feed each stage from the one before it
  always_comb begin
    rem_src[0] = in_mag[MAG_W-1:Q_W];
    qd_src[0]  = in_mag[Q_W-1:0];
    tg_src[0]  = in_tag;
    ng_src[0]  = in_neg;
    v_src[0]   = in_valid;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_src[s] = rem[s-1];
      qd_src[s]  = qd[s-1];
      tg_src[s]  = tg[s-1];
      ng_src[s]  = ng[s-1];
      v_src[s]   = v[s-1];
    end
  end

  // Shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    logic [D_W-1:0] r;
    logic [Q_W-1:0] q;
    logic [D_W:0]   trial;
    logic           ge;
    r     = '0;
    q     = '0;
    trial = '0;
    ge    = 1'b0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem_src[s];
      q = qd_src[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {r, q[Q_W-1]};
        ge    = (trial >= {1'b0, div_d});
        r     = ge ? D_W'(trial - {1'b0, div_d}) : trial[D_W-1:0];
        q     = {q[Q_W-2:0], ge};
      end
      rem_next[s] = r;
      qd_next[s]  = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (take[s]) begin
          v[s] <= v_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (take[s]) begin
        rem[s] <= rem_next[s];
        qd[s]  <= qd_next[s];
        tg[s]  <= tg_src[s];
        ng[s]  <= ng_src[s];
      end
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bezier_keyframe_interpolator_top
// Drives keyframe segments over several skip-count settings, predicts every
// in-between frame with exact wide-integer Bezier arithmetic and checks each
// result transaction, field by field and in order, against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bki_pkg::*;

  localparam int    CLK_HALF       = 4;
  localparam int    RESET_CYCLES   = 9;
  localparam int    IDLE_PCT       = 6;
  localparam int    DRAIN_CYCLES   = 24;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    RAND_PHASES    = 10;
  localparam int    RAND_ITEMS     = 25;
  localparam int    MAX_REPORTS    = 10;
  localparam longint SAT_HI        = 64'sd2147483647;
  localparam longint SAT_LO        = -64'sd2147483648;

  localparam logic signed [CP_W-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [CP_W-1:0] MINV = 32'sh8000_0000;
  localparam logic signed [CP_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [CP_W-1:0] NEG1 = 32'shFFFF_FFFF;

  // One keyframe segment as driven on the segment channel
  typedef struct {
    logic signed [CP_W-1:0] prev_val;
    logic signed [CP_W-1:0] start_val;
    logic signed [CP_W-1:0] end_val;
    logic signed [CP_W-1:0] next_val;
    logic                   has_prev;
    logic                   has_next;
  } seg_t;

  // One in-between frame as seen on the result channel
  typedef struct {
    logic signed [CP_W-1:0] value;
    logic [CNT_W-1:0]       frame_offset;
    logic                   last;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       skip_count  = '0;
  logic                   seg_valid   = 1'b0;
  logic                   seg_stall;
  logic signed [CP_W-1:0] prev_value  = '0;
  logic signed [CP_W-1:0] start_value = '0;
  logic signed [CP_W-1:0] end_value   = '0;
  logic signed [CP_W-1:0] next_value  = '0;
  logic                   has_prev    = 1'b0;
  logic                   has_next    = 1'b0;
  logic                   res_valid;
  logic                   res_stall   = 1'b0;
  logic signed [CP_W-1:0] value;
  logic [CNT_W-1:0]       frame_offset;
  logic                   last;

  seg_t             segment_queue[$];
  frame_t           expected_frames[$];
  seg_t             seg_cur;
  frame_t           exp_frame;
  logic [CNT_W-1:0] skip_mirror = 7'd1;
  logic             seg_taken   = 1'b0;
  logic             quiet       = 1'b0;
  int               idle_cycles = 0;
  int               fail_count  = 0;
  int               seg_count   = 0;
  int               frame_count = 0;
  int               cfg_count   = 0;

  bezier_keyframe_interpolator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .skip_count   (skip_count),
    .seg_valid    (seg_valid),
    .seg_stall    (seg_stall),
    .prev_value   (prev_value),
    .start_value  (start_value),
    .end_value    (end_value),
    .next_value   (next_value),
    .has_prev     (has_prev),
    .has_next     (has_next),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .value        (value),
    .frame_offset (frame_offset),
    .last         (last)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Compute every in-between frame of one segment and queue it
  function automatic void bezier_frames(input seg_t s, input logic [CNT_W-1:0] skip);
    longint p0, p1, p2, p3, a6, b6, n, n3, m, k, num, q;
    longint cnt;
    frame_t f;
    p0 = longint'(s.prev_val);
    p1 = longint'(s.start_val);
    p2 = longint'(s.end_val);
    p3 = longint'(s.next_val);
    cnt = (skip > CNT_W'(MAX_SKIP)) ? longint'(MAX_SKIP) : longint'(skip);
    // Inner points, kept as six times their value
    if (s.has_prev) a6 = 6 * p1 + p2 - p0;
    else if (s.has_next) a6 = 4 * p1 + 4 * p2 - 2 * p3;
    else a6 = 4 * p1 + 2 * p2;
    if (s.has_next) b6 = 6 * p2 - p3 + p1;
    else if (s.has_prev) b6 = 4 * p2 + 4 * p1 - 2 * p0;
    else b6 = 2 * p1 + 4 * p2;
    n = cnt + 1;
    n3 = n * n * n;
    for (k = 1; k <= cnt; k++) begin
      m = n - k;
      num = 6 * m * m * m * p1 + 3 * m * m * k * a6 + 3 * m * k * k * b6
          + 6 * k * k * k * p2;
      q = num / (6 * n3);
      if (q > SAT_HI) f.value = MAXV;
      else if (q < SAT_LO) f.value = MINV;
      else f.value = q[CP_W-1:0];
      f.frame_offset = k[CNT_W-1:0];
      f.last = (k == cnt);
      expected_frames.push_back(f);
    end
  endfunction

  // Pick a keyframe value: full range, small, extreme or whole units
  function automatic logic signed [CP_W-1:0] rand_val();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: return r;
      1: return {{12{r[19]}}, r[19:0]};
      2: begin
        case (r[1:0])
          2'd0: return MAXV;
          2'd1: return MINV;
          2'd2: return '0;
          default: return NEG1;
        endcase
      end
      default: return {r[31:16], 16'h0000};
    endcase
  endfunction

  task automatic add_seg(input logic signed [CP_W-1:0] pv, input logic signed [CP_W-1:0] sv,
                         input logic signed [CP_W-1:0] ev, input logic signed [CP_W-1:0] nv,
                         input logic hp, input logic hn);
    seg_t s;
    s.prev_val  = pv;
    s.start_val = sv;
    s.end_val   = ev;
    s.next_val  = nv;
    s.has_prev  = hp;
    s.has_next  = hn;
    segment_queue.push_back(s);
  endtask

  // Random segment: either a smooth local track or four unrelated values
  task automatic add_random_seg();
    logic signed [CP_W-1:0] base;
    logic [31:0] d;
    if ($urandom_range(1)) begin
      base = rand_val();
      d = $urandom;
      add_seg(base - {{20{d[7]}}, d[7:0], 4'h0}, base,
              base + {{20{d[15]}}, d[15:8], 4'h0},
              base + {{19{d[24]}}, d[24:16], 4'h0},
              1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      add_seg(rand_val(), rand_val(), rand_val(), rand_val(),
              1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Hold until every segment is taken and every frame has arrived
  task automatic wait_idle();
    while (segment_queue.size() != 0 || seg_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_skip(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    skip_count <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Segment driver: present the next pending segment once the last one is taken
  always @(negedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (!seg_valid || seg_taken) begin
      if (segment_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        seg_cur = segment_queue.pop_front();
        seg_valid   <= 1'b1;
        prev_value  <= seg_cur.prev_val;
        start_value <= seg_cur.start_val;
        end_value   <= seg_cur.end_val;
        next_value  <= seg_cur.next_val;
        has_prev    <= seg_cur.has_prev;
        has_next    <= seg_cur.has_next;
      end else begin
        seg_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: track config, predict on segment accept, check each frame
  always @(posedge clk) begin
    seg_taken = 1'b0;
    if (rst) begin
      skip_mirror = 7'd1;
    end else begin
      idle_cycles++;
      if (cfg_valid && cfg_ready) begin
        skip_mirror = skip_count;
        cfg_count++;
        idle_cycles = 0;
      end
      if (seg_valid && !seg_stall) begin
        seg_taken = 1'b1;
        bezier_frames(seg_cur, skip_mirror);
        seg_count++;
        idle_cycles = 0;
      end
      if (res_valid && !res_stall) begin
        idle_cycles = 0;
        frame_count++;
        if (expected_frames.size() == 0) begin
          flag_error($sformatf("unexpected frame value=%0d k=%0d last=%0b",
                               value, frame_offset, last));
        end else begin
          exp_frame = expected_frames.pop_front();
          if (value !== exp_frame.value || frame_offset !== exp_frame.frame_offset ||
              last !== exp_frame.last)
            flag_error($sformatf(
              "frame mismatch: exp value=%0d k=%0d last=%0b, got value=%0d k=%0d last=%0b",
              exp_frame.value, exp_frame.frame_offset, exp_frame.last,
              value, frame_offset, last));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    @(negedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [CNT_W-1:0] phase_skip[RAND_PHASES];
    logic [CNT_W-1:0] sk;
    phase_skip = '{7'd2, 7'd5, 7'd1, 7'd8, 7'd3, 7'd0, 7'd4, 7'd7, 7'd6, 7'd2};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes and every neighbor case at the reset count of one
    add_seg('0, '0, '0, '0, 1'b0, 1'b0);
    add_seg(MAXV, MAXV, MAXV, MAXV, 1'b1, 1'b1);
    add_seg(MINV, MINV, MINV, MINV, 1'b1, 1'b1);
    add_seg(MINV, MAXV, MAXV, MINV, 1'b1, 1'b1);
    add_seg(MAXV, MINV, MINV, MAXV, 1'b1, 1'b1);
    add_seg(MAXV, MINV, MAXV, MINV, 1'b0, 1'b0);
    add_seg('0, MINV, MAXV, MINV, 1'b0, 1'b1);
    add_seg(MAXV, MAXV, MINV, '0, 1'b1, 1'b0);
    wait_idle();

    // Directed: each neighbor rule on a gentle curve
    set_skip(7'd3);
    add_seg(32'sh0000_8000, ONE, 32'sh0003_0000, 32'sh0002_0000, 1'b1, 1'b1);
    add_seg(32'sh0000_8000, ONE, 32'sh0003_0000, 32'sh0002_0000, 1'b0, 1'b1);
    add_seg(32'sh0000_8000, ONE, 32'sh0003_0000, 32'sh0002_0000, 1'b1, 1'b0);
    add_seg(32'sh0000_8000, ONE, 32'sh0003_0000, 32'sh0002_0000, 1'b0, 1'b0);
    add_seg(NEG1, NEG1, 32'sh0000_0001, 32'sh0000_0001, 1'b1, 1'b1);
    add_seg(MAXV, '0, MINV, MAXV, 1'b1, 1'b1);
    wait_idle();

    // Zero count drops the segment
    set_skip(7'd0);
    add_random_seg();
    add_seg(MINV, MAXV, MINV, MAXV, 1'b1, 1'b1);
    wait_idle();

    // Counts above the maximum act as the maximum
    set_skip(7'd127);
    add_seg(MINV, MAXV, MINV, MAXV, 1'b1, 1'b1);
    add_seg('0, MINV, MAXV, '0, 1'b0, 1'b0);
    wait_idle();

    set_skip(7'd64);
    add_seg(ONE, '0, 32'sh0040_0000, '0, 1'b1, 1'b1);
    add_random_seg();
    wait_idle();

    // Random phases, mostly small counts; one phase runs with no idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sk = (ph % 4 == 3) ? 7'($urandom_range(10)) : phase_skip[ph];
      set_skip(sk);
      quiet = (ph == 2);
      for (int i = 0; i < RAND_ITEMS; i++) add_random_seg();
      wait_idle();
    end
    quiet = 1'b0;

    if (expected_frames.size() != 0)
      flag_error($sformatf("%0d frames never arrived", expected_frames.size()));
    $display("Run covered %0d segments and %0d frames across %0d skip-count writes,",
             seg_count, frame_count, cfg_count);
    $display("including zero, maximum and over-range counts and all neighbor cases.");
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d errors", fail_count);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
